[sv/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, types and stage controls of the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

    localparam int NUM_AXES   = 3;
    localparam int Q_W        = 32;
    localparam int HALF_W     = 31;
    localparam int OFF_W      = 34;
    localparam int FRAC_BITS  = 16;
    localparam int ENTRY_W    = 31;
    localparam int NUM_STAGES = 6;

    localparam int S_FIELDS_W = 3 * Q_W + 3 * HALF_W + 3 * Q_W + 3 * Q_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + ENTRY_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int PP_HI_W = (OFF_W - FRAC_BITS) + Q_W;
    localparam int PP_LO_W = (FRAC_BITS + 1) + Q_W;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic        [HALF_W-1:0] half_t;
    typedef logic signed [OFF_W-1:0]  off_t;

    typedef struct packed {
        logic en_pp;
        logic en_sum;
    } mul_ctl_t;

    typedef struct packed {
        logic en_slab;
        logic en_final;
    } red_ctl_t;

endpackage

`default_nettype wire

[sv/rbsi_offset.sv]
// ----------------------------------------------------------------------------
// rbsi_offset
// Slab offset stage: forms center - origin -/+ half per axis, exactly.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_offset (
    input  wire                  aclk,
    input  wire                  en,
    input  rbsi_pkg::q_t         center  [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::half_t      half    [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::q_t         origin  [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::q_t         inv_dir [rbsi_pkg::NUM_AXES],
    output rbsi_pkg::off_t       off_lo  [rbsi_pkg::NUM_AXES],
    output rbsi_pkg::off_t       off_hi  [rbsi_pkg::NUM_AXES],
    output rbsi_pkg::q_t         inv_out [rbsi_pkg::NUM_AXES]
);
    import rbsi_pkg::*;

    off_t off_lo_reg [NUM_AXES];
    off_t off_hi_reg [NUM_AXES];
    q_t   inv_reg    [NUM_AXES];
    off_t diff       [NUM_AXES];
    off_t half_ext   [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[i]     = OFF_W'(center[i]) - OFF_W'(origin[i]);
            half_ext[i] = off_t'({{(OFF_W - HALF_W){1'b0}}, half[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                off_lo_reg[i] <= diff[i] - half_ext[i];
                off_hi_reg[i] <= diff[i] + half_ext[i];
                inv_reg[i]    <= inv_dir[i];
            end
        end
    end

    assign off_lo  = off_lo_reg;
    assign off_hi  = off_hi_reg;
    assign inv_out = inv_reg;

endmodule

`default_nettype wire

[sv/rbsi_mul.sv]
// ----------------------------------------------------------------------------
// rbsi_mul
// Two-stage Q16.16 multiply: split partial products, then floor and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_mul (
    input  wire                  aclk,
    input  rbsi_pkg::mul_ctl_t   ctl,
    input  rbsi_pkg::off_t       a,
    input  rbsi_pkg::q_t         b,
    output rbsi_pkg::q_t         p
);
    import rbsi_pkg::*;

    localparam int SUM_W = PP_HI_W;

    logic signed [OFF_W-FRAC_BITS-1:0] a_hi;
    logic signed [FRAC_BITS:0]         a_lo;
    logic signed [PP_HI_W-1:0]         pp_hi_reg;
    logic signed [PP_LO_W-1:0]         pp_lo_reg;
    logic signed [PP_LO_W-1:0]         lo_shift;
    logic signed [SUM_W-1:0]           sum;
    logic                              sat_pos;
    logic                              sat_neg;
    q_t                                p_reg;
    q_t                                p_next;

    assign a_hi = a[OFF_W-1:FRAC_BITS];
    assign a_lo = {1'b0, a[FRAC_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (ctl.en_pp) begin
            pp_hi_reg <= a_hi * b;
            pp_lo_reg <= a_lo * b;
        end
    end

    // floor of the exact product over 2^16: arithmetic shift of the low part
    assign lo_shift = pp_lo_reg >>> FRAC_BITS;
    assign sum      = pp_hi_reg + SUM_W'(lo_shift);
    assign sat_pos  = !sum[SUM_W-1] && (|sum[SUM_W-2:Q_W-1]);
    assign sat_neg  = sum[SUM_W-1] && !(&sum[SUM_W-2:Q_W-1]);

    always_comb begin
        if (sat_pos) begin
            p_next = {1'b0, {(Q_W-1){1'b1}}};
        end else if (sat_neg) begin
            p_next = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            p_next = sum[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_sum) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[sv/rbsi_reduce.sv]
// ----------------------------------------------------------------------------
// rbsi_reduce
// Per-axis slab ordering, then near/far reduction, entry clamp and hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_reduce (
    input  wire                        aclk,
    input  rbsi_pkg::red_ctl_t         ctl,
    input  rbsi_pkg::q_t               d_lo [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::q_t               d_hi [rbsi_pkg::NUM_AXES],
    output logic                       hit,
    output logic [rbsi_pkg::ENTRY_W-1:0] entry_distance
);
    import rbsi_pkg::*;

    q_t                 s_min_reg [NUM_AXES];
    q_t                 s_max_reg [NUM_AXES];
    q_t                 near_d;
    q_t                 far_d;
    q_t                 entry;
    logic               hit_reg;
    logic [ENTRY_W-1:0] entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en_slab) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (d_lo[i] < d_hi[i]) begin
                    s_min_reg[i] <= d_lo[i];
                    s_max_reg[i] <= d_hi[i];
                end else begin
                    s_min_reg[i] <= d_hi[i];
                    s_max_reg[i] <= d_lo[i];
                end
            end
        end
    end

    always_comb begin
        near_d = s_min_reg[0];
        far_d  = s_max_reg[0];
        for (int i = 1; i < NUM_AXES; i++) begin
            if (s_min_reg[i] > near_d) begin
                near_d = s_min_reg[i];
            end
            if (s_max_reg[i] < far_d) begin
                far_d = s_max_reg[i];
            end
        end
        entry = (near_d > 0) ? near_d : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_final) begin
            hit_reg   <= (far_d >= entry);
            entry_reg <= entry[ENTRY_W-1:0];
        end
    end

    assign hit            = hit_reg;
    assign entry_distance = entry_reg;

endmodule

`default_nettype wire

[sv/ray_box_slab_intersection.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersection
// Ray versus axis-aligned box slab test in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata: box, ray (384 bits)
//  m_        out        m_tvalid / m_tready  m_tdata: hit, entry (32 bits)
//
//  One transaction per cycle sustained while m_tready stays high; six
//  register stages from input acceptance to result (input, offset, partial
//  products, floor and saturate, slab order, near/far reduction).
//  aresetn clears the stage valid bits only.
//  A stall on m_ holds full stages; empty stages still fill, so s_tready
//  stays high while any bubble remains in the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersection (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z,
    // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z, zero pad
    input  wire  [rbsi_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // hit, entry_distance
    output logic [rbsi_pkg::M_TDATA_W-1:0]    m_tdata
);
    import rbsi_pkg::*;

    localparam int CENTER_LSB = 0;
    localparam int HALF_LSB   = CENTER_LSB + NUM_AXES * Q_W;
    localparam int ORIGIN_LSB = HALF_LSB + NUM_AXES * HALF_W;
    localparam int INV_LSB    = ORIGIN_LSB + NUM_AXES * Q_W;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   rdy;

    q_t    center_reg [NUM_AXES];
    half_t half_reg   [NUM_AXES];
    q_t    origin_reg [NUM_AXES];
    q_t    inv_reg    [NUM_AXES];

    off_t  off_lo  [NUM_AXES];
    off_t  off_hi  [NUM_AXES];
    q_t    inv_s1  [NUM_AXES];
    q_t    d_lo    [NUM_AXES];
    q_t    d_hi    [NUM_AXES];

    mul_ctl_t           mul_ctl;
    red_ctl_t           red_ctl;
    logic               hit;
    logic [ENTRY_W-1:0] entry_distance;

    assign rdy[NUM_STAGES] = m_tready;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb begin
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                center_reg[i] <= s_tdata[CENTER_LSB + i*Q_W +: Q_W];
                half_reg[i]   <= s_tdata[HALF_LSB + i*HALF_W +: HALF_W];
                origin_reg[i] <= s_tdata[ORIGIN_LSB + i*Q_W +: Q_W];
                inv_reg[i]    <= s_tdata[INV_LSB + i*Q_W +: Q_W];
            end
        end
    end

    rbsi_offset u_offset (
        .aclk    (aclk),
        .en      (rdy[1]),
        .center  (center_reg),
        .half    (half_reg),
        .origin  (origin_reg),
        .inv_dir (inv_reg),
        .off_lo  (off_lo),
        .off_hi  (off_hi),
        .inv_out (inv_s1)
    );

    assign mul_ctl.en_pp  = rdy[2];
    assign mul_ctl.en_sum = rdy[3];

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        rbsi_mul u_mul_lo (
            .aclk (aclk),
            .ctl  (mul_ctl),
            .a    (off_lo[i]),
            .b    (inv_s1[i]),
            .p    (d_lo[i])
        );

        rbsi_mul u_mul_hi (
            .aclk (aclk),
            .ctl  (mul_ctl),
            .a    (off_hi[i]),
            .b    (inv_s1[i]),
            .p    (d_hi[i])
        );
    end

    assign red_ctl.en_slab  = rdy[4];
    assign red_ctl.en_final = rdy[5];

    rbsi_reduce u_reduce (
        .aclk           (aclk),
        .ctl            (red_ctl),
        .d_lo           (d_lo),
        .d_hi           (d_hi),
        .hit            (hit),
        .entry_distance (entry_distance)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = M_TDATA_W'({entry_distance, hit});

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/box slab test pipeline.
// Each box/ray transaction accepted on s_ is run through a Q16.16 slab
// predictor, and each result on m_ is compared against the oldest prediction.
// Stimulus: hand-picked edge cases (axis-parallel rays, point boxes, corner
// touches, saturation, floor rounding), then a mix of aimed scenes and raw
// random bit patterns, with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb;

    import rbsi_pkg::*;

    localparam longint ONE   = 64'sd65536;
    localparam longint Q_TOP = 64'sd2147483647;
    localparam longint Q_BOT = -64'sd2147483648;

    // center_x .. inv_dir_z from the lowest bit up, zero pad on top
    typedef struct packed {
        logic [2:0]  pad;
        q_t [2:0]    inv_dir;
        q_t [2:0]    origin;
        half_t [2:0] half;
        q_t [2:0]    center;
    } box_ray_t;

    // hit, entry_distance from the lowest bit up
    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic               hit;
    } slab_result_t;

    class slab_scoreboard;
        slab_result_t pending_results[$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  hits;

        function new();
            errors  = 0;
            checked = 0;
            hits    = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20)
                $display("tb: mismatch: %s", msg);
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        // floor(offset * inv_dir / 2^16), saturated to Q16.16
        static function longint slab_dist(longint off, longint inv);
            logic signed [67:0] prod;
            prod = off * inv;
            prod = prod >>> FRAC_BITS;
            if (prod > 68'sd2147483647)
                return Q_TOP;
            if (prod < -68'sd2147483648)
                return Q_BOT;
            return longint'(prod);
        endfunction

        function void note_box_ray(logic [S_TDATA_W-1:0] tdata);
            box_ray_t     item;
            slab_result_t res;
            longint       near_d, far_d, entry, off, h, lo, hi, tmp;
            int           ax;
            item   = tdata;
            near_d = Q_BOT;
            far_d  = Q_TOP;
            for (ax = 0; ax < NUM_AXES; ax++) begin
                h   = longint'(item.half[ax]);
                off = longint'($signed(item.center[ax])) - longint'($signed(item.origin[ax]));
                lo  = slab_dist(off - h, longint'($signed(item.inv_dir[ax])));
                hi  = slab_dist(off + h, longint'($signed(item.inv_dir[ax])));
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (lo > near_d)
                    near_d = lo;
                if (hi < far_d)
                    far_d = hi;
            end
            entry     = (near_d > 0) ? near_d : 0;
            res.hit   = (far_d >= entry);
            res.entry = entry[ENTRY_W-1:0];
            pending_results.push_back(res);
        endfunction

        task check_result(logic [M_TDATA_W-1:0] tdata);
            slab_result_t got;
            slab_result_t want;
            got = tdata;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit)
                    report($sformatf("result %0d hit %b, predicted %b",
                                     checked, got.hit, want.hit));
                if (got.entry !== want.entry)
                    report($sformatf("result %0d entry_distance 0x%08h, predicted 0x%08h",
                                     checked, got.entry, want.entry));
                if (want.hit)
                    hits++;
            end
            checked++;
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    bit                   idle_on  = 1'b1;

    slab_scoreboard sb = new();

    ray_box_slab_intersection DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_box_ray(s_tdata);
        end
    end

    // result side: random stall bursts while idling is on
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 4);
            end
        end
    end

    function automatic box_ray_t make_box_ray(longint cx, longint cy, longint cz,
                                              longint hx, longint hy, longint hz,
                                              longint ox, longint oy, longint oz,
                                              longint ix, longint iy, longint iz);
        box_ray_t item;
        item            = '0;
        item.center[0]  = q_t'(cx);
        item.center[1]  = q_t'(cy);
        item.center[2]  = q_t'(cz);
        item.half[0]    = half_t'(hx);
        item.half[1]    = half_t'(hy);
        item.half[2]    = half_t'(hz);
        item.origin[0]  = q_t'(ox);
        item.origin[1]  = q_t'(oy);
        item.origin[2]  = q_t'(oz);
        item.inv_dir[0] = q_t'(ix);
        item.inv_dir[1] = q_t'(iy);
        item.inv_dir[2] = q_t'(iz);
        return item;
    endfunction

    function automatic longint signed_span(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // mostly rays aimed at a box with jitter, some raw bit patterns
    function automatic box_ray_t random_box_ray();
        box_ray_t item;
        longint   o, d, t, inv;
        int       ax, kind;
        item = '0;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            for (ax = 0; ax < NUM_AXES; ax++) begin
                item.center[ax]  = $urandom;
                item.half[ax]    = half_t'($urandom);
                item.origin[ax]  = $urandom;
                item.inv_dir[ax] = $urandom;
            end
        end else begin
            t = longint'($urandom_range(0, 32'(32 * ONE)));
            if (kind == 3)
                t = -t;
            for (ax = 0; ax < NUM_AXES; ax++) begin
                o = signed_span(64 * ONE);
                d = signed_span(4 * ONE);
                if ($urandom_range(0, 5) == 0)
                    d = 0;
                if (d == 0) begin
                    inv = ($urandom_range(0, 1) == 1) ? Q_TOP : Q_BOT;
                end else begin
                    inv = (64'sd1 <<< 32) / d;
                    if (inv > Q_TOP)
                        inv = Q_TOP;
                    if (inv < Q_BOT)
                        inv = Q_BOT;
                end
                item.origin[ax]  = q_t'(o);
                item.inv_dir[ax] = q_t'(inv);
                item.center[ax]  = q_t'(o + ((d * t) >>> FRAC_BITS) + signed_span(2 * ONE));
                if ($urandom_range(0, 7) == 0)
                    item.half[ax] = '0;
                else
                    item.half[ax] = half_t'($urandom_range(0, 32'(4 * ONE)));
            end
        end
        return item;
    endfunction

    task automatic send_box_ray(box_ray_t item);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int n;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ray starts inside a unit box
        send_box_ray(make_box_ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
        // axis-parallel ray, box ahead and behind
        send_box_ray(make_box_ray(10 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, Q_TOP, Q_TOP));
        send_box_ray(make_box_ray(10 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0, -ONE, Q_BOT, Q_BOT));
        // zero inverse direction
        send_box_ray(make_box_ray(5 * ONE, 5 * ONE, 5 * ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        // empty boxes on and off the ray
        send_box_ray(make_box_ray(4 * ONE, 4 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        send_box_ray(make_box_ray(4 * ONE, 5 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        // field extremes and saturation
        send_box_ray(make_box_ray(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                                  Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP));
        send_box_ray(make_box_ray(Q_BOT, Q_BOT, Q_BOT, 0, 0, 0,
                                  Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT));
        send_box_ray(make_box_ray(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                                  Q_BOT, Q_BOT, Q_BOT, Q_TOP, Q_TOP, Q_TOP));
        send_box_ray(make_box_ray(Q_BOT, Q_BOT, Q_BOT, Q_TOP, Q_TOP, Q_TOP,
                                  Q_TOP, Q_TOP, Q_TOP, Q_BOT, Q_BOT, Q_BOT));
        send_box_ray(make_box_ray(Q_BOT, Q_BOT, Q_BOT, 0, 0, 0,
                                  Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP));
        // floor rounding of a tiny negative product
        send_box_ray(make_box_ray(-1, -1, -1, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        // corner touch, then a miss by one LSB with entry still reported
        send_box_ray(make_box_ray(2 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, Q_TOP));
        send_box_ray(make_box_ray(2 * ONE, 0, 0, ONE, ONE - 1, ONE, 0, 0, 0, ONE, ONE, Q_TOP));
        // origin inside a huge box, negative entry clamps to zero
        send_box_ray(make_box_ray(0, 0, 0, Q_TOP, Q_TOP, Q_TOP,
                                  ONE, -ONE, 3 * ONE, 2 * ONE, -ONE, ONE / 2));
        // box along the negative diagonal
        send_box_ray(make_box_ray(-8 * ONE, -8 * ONE, -8 * ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                                  0, 0, 0, -ONE, -ONE, -ONE));
        send_box_ray(make_box_ray(ONE, 2 * ONE, 3 * ONE, ONE / 2, ONE / 2, ONE / 2,
                                  0, 0, 0, Q_BOT, Q_TOP, 0));
        send_box_ray(make_box_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_box_ray(make_box_ray(Q_TOP, Q_TOP, Q_TOP, 0, 0, 0,
                                  Q_BOT, Q_BOT, Q_BOT, 1, 1, 1));
        wait_results_drained();

        for (n = 0; n < 700; n++) begin
            if (n == 350)
                wait_results_drained();
            if (n == 560)
                idle_on = 1'b0;
            send_box_ray(random_box_ray());
        end
        wait_results_drained();
        repeat (12) @(posedge aclk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d predictions never answered", sb.pending()));
        $display("tb: %0d box/ray transactions checked, %0d hits, %0d misses",
                 sb.checked, sb.hits, sb.checked - sb.hits);
        $display("tb: edge cases, aimed scenes and raw patterns under random stalls");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
